// ===== src/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define C2GWS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("c2gws assertion failed");

// Property checked on every rising edge, reset included.
`define C2GWS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("c2gws assertion failed during reset");

`endif

// ===== src/c2gws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2gws_pkg
// Types and constants for the calendar to GPS week/seconds pipeline.
// ----------------------------------------------------------------------------
package c2gws_pkg;

  localparam logic [11:0] EPOCH_YEAR = 12'd1980;
  // Leap years through 1979, plus the five days from 1 to 6 January 1980.
  localparam logic [21:0] EPOCH_DAY_BIAS = 22'd484;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_MAR = 4'd3;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  // floor(y / 100) = (y * 5243) >> 19 for any 12-bit y.
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  // floor(t / 7) = (t * 1198373) >> 23 for any 20-bit t.
  localparam logic [20:0] DIV7_MUL = 21'd1198373;
  localparam int unsigned DIV7_SHIFT = 23;

  localparam logic [19:0] SEC_PER_DAY = 20'd86400;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  typedef struct packed {
    logic               early;  // year before the epoch year
    logic signed [20:0] base;   // days from epoch to 1 January of the year
    logic [9:0]         doy;    // two's complement day of year
    logic [16:0]        tod;    // seconds into the day
  } day_calc_t;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== src/c2gws_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2gws channel interfaces
// Valid/ready channels for date words in and GPS time words out.
// ----------------------------------------------------------------------------
interface c2gws_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface c2gws_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] seconds_of_week;
  logic [13:0] gps_week;
  logic [8:0]  day_of_year;
  logic        before_epoch;

  modport source (output valid, seconds_of_week, gps_week, day_of_year, before_epoch,
                  input ready);
  modport sink   (input valid, seconds_of_week, gps_week, day_of_year, before_epoch,
                  output ready);
endinterface
`default_nettype wire

// ===== src/c2gws_date_stages.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2gws_date_stages
// First two pipeline stages: century quotients, month offset and time of
// day, then the day count to 1 January and the signed day of year.
// ----------------------------------------------------------------------------
module c2gws_date_stages (
  input  wire logic                 clk,
  input  wire c2gws_pkg::stage_en_t en,
  input  wire logic [11:0]          year,
  input  wire logic [3:0]           month,
  input  wire logic [4:0]           day,
  input  wire logic [4:0]           hour,
  input  wire logic [5:0]           minute,
  input  wire logic [5:0]           second,
  output c2gws_pkg::day_calc_t      calc_o
);

  // Stage 1 registers
  logic [11:0] year_r;
  logic [5:0]  q_y_r;
  logic [5:0]  q_ym1_r;
  logic [8:0]  mstart_r;
  logic        mvalid_r;
  logic        mlate_r;
  logic [4:0]  day_r;
  logic [16:0] tod_r;

  logic [11:0] ym1;
  logic [24:0] prod_y;
  logic [24:0] prod_ym1;
  logic [16:0] tod_nxt;

  // Stage 2
  c2gws_pkg::day_calc_t calc_r;
  c2gws_pkg::day_calc_t calc_nxt;
  logic [11:0] years;
  logic [11:0] ym1_s2;
  logic [21:0] leaps_raw;
  logic [21:0] base_u;
  logic        is_leap;

  assign ym1      = year - 12'd1;
  assign prod_y   = 25'(year) * 25'(c2gws_pkg::DIV100_MUL);
  assign prod_ym1 = 25'(ym1) * 25'(c2gws_pkg::DIV100_MUL);
  assign tod_nxt  = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      year_r   <= year;
      q_y_r    <= prod_y[c2gws_pkg::DIV100_SHIFT +: 6];
      q_ym1_r  <= prod_ym1[c2gws_pkg::DIV100_SHIFT +: 6];
      mstart_r <= c2gws_pkg::month_start(month);
      mvalid_r <= (month >= c2gws_pkg::MONTH_JAN) && (month <= c2gws_pkg::MONTH_DEC);
      mlate_r  <= (month >= c2gws_pkg::MONTH_MAR);
      day_r    <= day;
      tod_r    <= tod_nxt;
    end
  end

  always_comb begin
    years  = year_r - c2gws_pkg::EPOCH_YEAR;
    ym1_s2 = year_r - 12'd1;
    // year % 100 == 0 exactly when the quotient times 100 gives the year back
    is_leap = (year_r[1:0] == 2'd0) &&
              ((year_r != 12'(q_y_r) * 12'd100) || (q_y_r[1:0] == 2'd0));
    leaps_raw = 22'(ym1_s2[11:2]) - 22'(q_ym1_r) + 22'(q_ym1_r[5:2]);
    base_u    = 22'(years) * 22'd365 + leaps_raw - c2gws_pkg::EPOCH_DAY_BIAS;

    calc_nxt.early = (year_r < c2gws_pkg::EPOCH_YEAR);
    calc_nxt.base  = $signed(base_u[20:0]);
    calc_nxt.tod   = tod_r;
    if (mvalid_r) begin
      calc_nxt.doy = 10'(mstart_r) + 10'(day_r) - 10'd1 + 10'(is_leap && mlate_r);
    end else begin
      calc_nxt.doy = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      calc_r <= calc_nxt;
    end
  end

  assign calc_o = calc_r;

endmodule
`default_nettype wire

// ===== src/calendar_to_gps_week_seconds_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_to_gps_week_seconds_core
// Gregorian date and time of day to GPS week, seconds of week and day of year.
// ----------------------------------------------------------------------------
// Four-stage pipeline that takes one date word per clock unless an output
// stall reaches back to the input. Stage one forms the century quotients
// by reciprocal multiplication, stage two the day count to 1 January and the
// day of year, stage three the total day count and the week by a reciprocal
// multiply by one seventh, and stage four (the output register) the seconds
// of week. Each stage holds its own valid bit and ready ripples back stage by
// stage, so bubbles are squeezed out while the output is stalled and words
// keep being accepted until all four stages are full. Dates before 6 January
// 1980 come out with before_epoch set and the other fields zero.
module calendar_to_gps_week_seconds_core (
  input wire logic    clk,
  input wire logic    rst_n,
  c2gws_in_if.sink    in_chan,
  c2gws_out_if.source out_chan
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  c2gws_pkg::stage_en_t stage_en;
  c2gws_pkg::day_calc_t calc;

  // Stage 3
  logic signed [20:0] total;
  logic [40:0]        prod7;
  logic [19:0]        total_r;
  logic [17:0]        week_r;
  logic               bad_r;
  logic [8:0]         doy_r;
  logic [16:0]        tod_r;

  // Stage 4
  logic [2:0]  rem7;
  logic [19:0] sow_nxt;
  logic [19:0] sow_r;
  logic [13:0] week_out_r;
  logic [8:0]  doy_out_r;
  logic        bad_out_r;

  assign en4 = !v4_r || out_chan.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_chan.ready = en1;

  assign stage_en.s1 = en1;
  assign stage_en.s2 = en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_chan.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  c2gws_date_stages u_date (
    .clk    (clk),
    .en     (stage_en),
    .year   (in_chan.year),
    .month  (in_chan.month),
    .day    (in_chan.day),
    .hour   (in_chan.hour),
    .minute (in_chan.minute),
    .second (in_chan.second),
    .calc_o (calc)
  );

  assign total = calc.base + 21'($signed(calc.doy));
  assign prod7 = 41'(total[19:0]) * 41'(c2gws_pkg::DIV7_MUL);

  always_ff @(posedge clk) begin
    if (en3) begin
      total_r <= total[19:0];
      week_r  <= prod7[c2gws_pkg::DIV7_SHIFT +: 18];
      bad_r   <= calc.early || total[20];
      doy_r   <= calc.doy[8:0];
      tod_r   <= calc.tod;
    end
  end

  // Remainder of the week division, then whole days of the week in seconds plus the time of day
  always_comb begin
    rem7    = 3'(total_r - 20'(week_r) * 20'd7);
    sow_nxt = 20'(rem7) * c2gws_pkg::SEC_PER_DAY + 20'(tod_r);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      bad_out_r  <= bad_r;
      sow_r      <= bad_r ? 20'd0 : sow_nxt;
      week_out_r <= bad_r ? 14'd0 : week_r[13:0];
      doy_out_r  <= bad_r ? 9'd0 : doy_r;
    end
  end

  assign out_chan.valid           = v4_r;
  assign out_chan.seconds_of_week = sow_r;
  assign out_chan.gps_week        = week_out_r;
  assign out_chan.day_of_year     = doy_out_r;
  assign out_chan.before_epoch    = bad_out_r;

endmodule
`default_nettype wire

// ===== src/c2gws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// c2gws_checker
// Port-level checks on the GPS time pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module c2gws_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [19:0] out_sow,
  input wire logic [13:0] out_week,
  input wire logic [8:0]  out_doy,
  input wire logic        out_before
);

  logic [2:0] inflight_r;
  logic [2:0] inflight_nxt;
  logic       in_acc;
  logic       out_acc;
  logic       out_zero;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign out_zero = (out_sow == 20'd0) && (out_week == 14'd0) && (out_doy == 9'd0);

  always_comb begin
    inflight_nxt = inflight_r + 3'(in_acc) - 3'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 3'd0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // no word appears without one accepted, and at most four are held
  `C2GWS_ASSERT(a_no_invented, clk, rst_n, out_valid |-> (inflight_r != 3'd0))
  `C2GWS_ASSERT(a_depth, clk, rst_n, inflight_r <= 3'd4)
  `C2GWS_ASSERT(a_early_zero, clk, rst_n, (out_valid && out_before) |-> out_zero)
  `C2GWS_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  `C2GWS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind calendar_to_gps_week_seconds_core c2gws_checker u_c2gws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_sow    (out_chan.seconds_of_week),
  .out_week   (out_chan.gps_week),
  .out_doy    (out_chan.day_of_year),
  .out_before (out_chan.before_epoch)
);
`default_nettype wire
